FILE: hdl/frame_rate_gate_byte_budget_assert.svh
// Assertion macros for the frame rate gate and byte budget block.
// Each macro expects clk and arst_n in scope.
`ifndef FRAME_RATE_GATE_BYTE_BUDGET_ASSERT_SVH
`define FRAME_RATE_GATE_BYTE_BUDGET_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define FRGBB_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("frgbb invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define FRGBB_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frgbb implication violated");

// Consequent must hold in the cycle after the antecedent.
`define FRGBB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frgbb next-cycle check violated");

`endif

FILE: hdl/frgbb_pkg.sv
package frgbb_pkg;

	localparam int TS_W       = 48;
	localparam int PTS_W      = 56;
	localparam int BYTES_W    = 24;
	localparam int WBYTES_W   = 40;
	localparam int FPS_W      = 10;
	localparam int KBPS_W     = 20;
	localparam int IV_W       = 10;
	localparam int BUDGET_W   = 27;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 20;

	// Window length in ms
	localparam logic [TS_W-1:0] WINDOW_MS = 48'd1000;

	// pts/1000 = (pts/8)/125, long division by 125 in 14-bit digits
	localparam int CHUNK_W     = 14;
	localparam int REM_W       = 7;
	localparam int X_W         = REM_W + CHUNK_W;
	localparam int DIV_STEPS   = PTS_W / CHUNK_W;
	localparam int RECIP_W     = 22;
	localparam int PROD_W      = X_W + RECIP_W;
	localparam int RECIP_SHIFT = 28;
	localparam int DIVISOR     = 125;
	localparam logic [RECIP_W-1:0] RECIP125 = 22'd2147484;

	localparam int BYTES_PER_KBIT = 125;

	localparam logic [FPS_W-1:0]  FPS_RST  = 10'd30;
	localparam logic [KBPS_W-1:0] KBPS_RST = 20'd4000;
	localparam logic [KBPS_W-1:0] KBPS_MIN = 20'd100;

	localparam logic [CFG_IDX_W-1:0] REG_TARGET_FPS  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_KBPS = 1'd1;

	localparam logic CMD_FRAME  = 1'b0;
	localparam logic CMD_PACKET = 1'b1;

	typedef enum logic [1:0] {
		RSN_OK       = 2'd0,
		RSN_EARLY    = 2'd1,
		RSN_OVER     = 2'd2,
		RSN_KEY_OVER = 2'd3
	} reason_t;

	// floor(1000/f) for f below 32, f = 0 treated as 1
	localparam logic [IV_W-1:0] INTERVAL_LUT [32] = '{
		10'd1000, 10'd1000, 10'd500, 10'd333, 10'd250, 10'd200, 10'd166, 10'd142,
		10'd125,  10'd111,  10'd100, 10'd90,  10'd83,  10'd76,  10'd71,  10'd66,
		10'd62,   10'd58,   10'd55,  10'd52,  10'd50,  10'd47,  10'd45,  10'd43,
		10'd41,   10'd40,   10'd38,  10'd37,  10'd35,  10'd34,  10'd33,  10'd32
	};

	// Fields carried down the time pipeline
	typedef struct packed {
		logic               command;
		logic [TS_W-1:0]    frame_ts_ms;
		logic [TS_W-1:0]    ingest_ts_ms;
		logic [BYTES_W-1:0] packet_bytes;
		logic               is_keyframe;
	} beat_t;

	// Item as seen by the policing stage
	typedef struct packed {
		logic               command;
		logic [TS_W-1:0]    ts_ms;
		logic [TS_W-1:0]    ingest_ts_ms;
		logic [BYTES_W-1:0] packet_bytes;
		logic               is_keyframe;
	} item_t;

	typedef struct packed {
		logic [CHUNK_W-1:0] q;
		logic [REM_W-1:0]   r;
	} div_step_t;

	// One digit of division by 125; exact for every rem below 125
	function automatic div_step_t div125_step(input logic [REM_W-1:0] rem,
			input logic [CHUNK_W-1:0] chunk);
		logic [X_W-1:0]    x;
		logic [PROD_W-1:0] prod;
		div_step_t         res;
		x      = {rem, chunk};
		prod   = PROD_W'(x) * PROD_W'(RECIP125);
		res.q  = prod[RECIP_SHIFT +: CHUNK_W];
		res.r  = REM_W'(x - X_W'(res.q) * X_W'(DIVISOR));
		return res;
	endfunction

	// max(1, floor(1000 / max(1, f)))
	function automatic logic [IV_W-1:0] fps_interval(input logic [FPS_W-1:0] f);
		logic [IV_W-1:0] q;
		logic [13:0]     rem;
		logic [13:0]     dv;
		q   = '0;
		rem = 14'd1000;
		if (f < 10'd32) begin
			q = INTERVAL_LUT[f[4:0]];
		end else begin
			for (int k = 4; k >= 0; k--) begin
				dv = 14'(f) << k;
				if (rem >= dv) begin
					rem  = rem - dv;
					q[k] = 1'b1;
				end
			end
		end
		// rates above 1000 fps still keep a 1 ms interval
		if (q == '0) begin
			q = 10'd1;
		end
		return q;
	endfunction

	// max(100, kbps) * 125
	function automatic logic [BUDGET_W-1:0] kbps_budget(input logic [KBPS_W-1:0] v);
		logic [KBPS_W-1:0] k;
		k = (v < KBPS_MIN) ? KBPS_MIN : v;
		return BUDGET_W'(k) * BUDGET_W'(BYTES_PER_KBIT);
	endfunction

endpackage

FILE: hdl/frgbb_if.sv
interface frgbb_item_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [47:0] frame_ts_ms;
	logic [55:0] pts_us;
	logic [47:0] ingest_ts_ms;
	logic [23:0] packet_bytes;
	logic        is_keyframe;

	modport source (output valid, command, frame_ts_ms, pts_us, ingest_ts_ms,
		packet_bytes, is_keyframe, input ready);
	modport sink (input valid, command, frame_ts_ms, pts_us, ingest_ts_ms,
		packet_bytes, is_keyframe, output ready);
endinterface

interface frgbb_result_if;
	logic       valid;
	logic       ready;
	logic       accept;
	logic [1:0] reason;

	modport source (output valid, accept, reason, input ready);
	modport sink (input valid, accept, reason, output ready);
endinterface

FILE: hdl/frgbb_time_pipe.sv
module frgbb_time_pipe import frgbb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	frgbb_item_if.sink items,
	output item_t itm,
	output logic  itm_valid,
	input  logic  itm_ready
);

	localparam int STAGES = DIV_STEPS + 1;

	logic [STAGES-1:0] vld_s;
	logic [STAGES:0]   adv;
	beat_t             beat_s [STAGES];
	logic [PTS_W-1:0]  work_s [STAGES];
	logic [REM_W-1:0]  rem_s  [DIV_STEPS];
	div_step_t         step   [DIV_STEPS];

	// a stage moves when it is empty or the next one moves
	always_comb begin
		adv[STAGES] = itm_ready;
		for (int i = STAGES - 1; i >= 0; i--) begin
			adv[i] = !vld_s[i] || adv[i+1];
		end
	end

	assign items.ready = adv[0];

	always_comb begin
		for (int i = 0; i < DIV_STEPS; i++) begin
			step[i] = div125_step(rem_s[i], work_s[i][PTS_W-1 -: CHUNK_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) begin
				vld_s[0] <= items.valid;
			end
			for (int i = 1; i < STAGES; i++) begin
				if (adv[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	// work word: remaining dividend digits on top, quotient digits shift in below
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			beat_s[0] <= '{command:      items.command,
			               frame_ts_ms:  items.frame_ts_ms,
			               ingest_ts_ms: items.ingest_ts_ms,
			               packet_bytes: items.packet_bytes,
			               is_keyframe:  items.is_keyframe};
			work_s[0] <= {3'b000, items.pts_us[PTS_W-1:3]};
			rem_s[0]  <= '0;
		end
		for (int i = 1; i < STAGES; i++) begin
			if (adv[i]) begin
				beat_s[i] <= beat_s[i-1];
				work_s[i] <= {work_s[i-1][PTS_W-CHUNK_W-1:0], step[i-1].q};
			end
		end
		for (int i = 1; i < DIV_STEPS; i++) begin
			if (adv[i]) begin
				rem_s[i] <= step[i-1].r;
			end
		end
	end

	assign itm_valid        = vld_s[STAGES-1];
	assign itm.command      = beat_s[STAGES-1].command;
	assign itm.ts_ms        = (beat_s[STAGES-1].frame_ts_ms != '0) ?
		beat_s[STAGES-1].frame_ts_ms : work_s[STAGES-1][TS_W-1:0];
	assign itm.ingest_ts_ms = beat_s[STAGES-1].ingest_ts_ms;
	assign itm.packet_bytes = beat_s[STAGES-1].packet_bytes;
	assign itm.is_keyframe  = beat_s[STAGES-1].is_keyframe;

endmodule

FILE: hdl/frame_rate_gate_byte_budget.sv
// Frame rate gate and byte budget policer. Each input beat is either a frame
// arrival (command 0), checked against a due time that advances by
// max(1, floor(1000/target_fps)) ms per passed frame and catches up when a
// frame lags by more than three intervals, or an encoded packet (command 1),
// checked against a fixed 1000 ms byte window with a budget of
// max(100, target_kbps)*125 bytes; keyframes always pass but still count.
// A missing frame timestamp falls back to pts_us/1000, and for packets then
// to the ingest time. Every input beat gives exactly one result beat. The
// block takes one beat per clock cycle unless back-pressure stalls it. A beat
// passes through one input register, four stages of the pts_us
// divide-by-1000 (one 14-bit digit each, the last of which holds the item
// time), then the policing logic feeding the result register. Back-pressure
// stalls each stage only when it is full. Configuration writes take effect on
// the next cycle and must only be issued while the block is empty.
`include "frame_rate_gate_byte_budget_assert.svh"

module frame_rate_gate_byte_budget import frgbb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	frgbb_item_if.sink            items,
	frgbb_result_if.source        results,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	// item time pipeline output
	item_t itm;
	logic  itm_valid;
	logic  itm_ready;
	logic  fire;

	// configuration
	logic [IV_W-1:0]     interval_q;
	logic [BUDGET_W-1:0] budget_q;

	// policing state
	logic [TS_W-1:0]     next_due_q;
	logic [TS_W-1:0]     win_start_q;
	logic [TS_W:0]       win_end_q;
	logic [WBYTES_W-1:0] wbytes_q;

	// result register
	logic    res_vld_q;
	logic    res_accept_q;
	reason_t res_reason_q;

	// next-state values
	logic [TS_W-1:0]     due;
	logic [TS_W+1:0]     due_step;
	logic [TS_W+1:0]     due_late;
	logic [TS_W-1:0]     now;
	logic                restart;
	logic [WBYTES_W-1:0] base;
	logic [WBYTES_W:0]   sum;
	logic                over;
	logic                nxt_accept;
	reason_t             nxt_reason;
	logic [TS_W-1:0]     nxt_due;
	logic [TS_W-1:0]     nxt_win_start;
	logic [WBYTES_W-1:0] nxt_wbytes;
	logic                pkt_ok;

	frgbb_time_pipe u_time (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.itm       (itm),
		.itm_valid (itm_valid),
		.itm_ready (itm_ready)
	);

	// the result register frees up as soon as its beat is taken
	assign itm_ready = !res_vld_q || results.ready;
	assign fire      = itm_valid && itm_ready;

	// Work out derived values at write time: interval and byte budget.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= fps_interval(FPS_RST);
			budget_q   <= kbps_budget(KBPS_RST);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_TARGET_FPS:  interval_q <= fps_interval(cfg_wdata[FPS_W-1:0]);
				REG_TARGET_KBPS: budget_q   <= kbps_budget(cfg_wdata[KBPS_W-1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		// Frame gate: a zero due time means the gate has not started, so
		// start it at this frame's time. A passed frame advances the due
		// time by one interval, or restarts from the frame time when the
		// frame is more than three intervals past the advanced due time
		// (due + 4 intervals covers that check in one add).
		due      = (next_due_q == '0) ? itm.ts_ms : next_due_q;
		due_step = (TS_W+2)'(due) + (TS_W+2)'(interval_q);
		due_late = (TS_W+2)'(due) + (TS_W+2)'({interval_q, 2'b00});

		// Byte window: the clock falls back to the ingest time. A restart
		// clears the count; the window start only follows a nonzero clock.
		now     = (itm.ts_ms != '0) ? itm.ts_ms : itm.ingest_ts_ms;
		restart = (win_start_q == '0) || (now == '0) || ((TS_W+1)'(now) >= win_end_q);
		base    = restart ? '0 : wbytes_q;
		sum     = (WBYTES_W+1)'(base) + (WBYTES_W+1)'(itm.packet_bytes);
		over    = sum > (WBYTES_W+1)'(budget_q);

		nxt_accept    = 1'b1;
		nxt_reason    = RSN_OK;
		nxt_due       = next_due_q;
		nxt_win_start = win_start_q;
		nxt_wbytes    = wbytes_q;

		case (itm.command)
			CMD_FRAME: begin
				// a frame without any time passes and leaves the gate alone
				if (itm.ts_ms != '0) begin
					if (itm.ts_ms < due) begin
						nxt_accept = 1'b0;
						nxt_reason = RSN_EARLY;
						nxt_due    = due;
					end else if ((TS_W+2)'(itm.ts_ms) > due_late) begin
						nxt_due = itm.ts_ms + TS_W'(interval_q);
					end else begin
						// wrap modulo 2^48; a wrap to zero restarts the gate
						nxt_due = due_step[TS_W-1:0];
					end
				end
			end
			CMD_PACKET: begin
				if (restart && (now != '0)) begin
					nxt_win_start = now;
				end
				nxt_wbytes = base;
				if (over && !itm.is_keyframe) begin
					nxt_accept = 1'b0;
					nxt_reason = RSN_OVER;
				end else begin
					if (over) begin
						nxt_reason = RSN_KEY_OVER;
					end
					// saturate the byte count
					nxt_wbytes = sum[WBYTES_W] ? '1 : sum[WBYTES_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// Hold state; advance it only when a beat moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_due_q  <= '0;
			win_start_q <= '0;
			win_end_q   <= (TS_W+1)'(WINDOW_MS);
			wbytes_q    <= '0;
			res_vld_q   <= 1'b0;
		end else begin
			if (fire) begin
				next_due_q  <= nxt_due;
				win_start_q <= nxt_win_start;
				win_end_q   <= (TS_W+1)'(nxt_win_start) + (TS_W+1)'(WINDOW_MS);
				wbytes_q    <= nxt_wbytes;
			end
			if (itm_ready) begin
				res_vld_q <= itm_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_accept_q <= nxt_accept;
			res_reason_q <= nxt_reason;
		end
	end

	assign results.valid  = res_vld_q;
	assign results.accept = res_accept_q;
	assign results.reason = res_reason_q;

	// a within-budget packet never leaves more bytes than the budget
	assign pkt_ok = fire && (itm.command == CMD_PACKET) && (nxt_reason == RSN_OK);

	`FRGBB_ASSERT_ALWAYS(a_win_end_tracks_start,
		win_end_q == (TS_W+1)'(win_start_q) + (TS_W+1)'(WINDOW_MS))
	`FRGBB_ASSERT_IMPLIES(a_reject_has_cause, results.valid && !results.accept,
		results.reason == RSN_EARLY || results.reason == RSN_OVER)
	`FRGBB_ASSERT_NEXT(a_ok_within_budget, pkt_ok,
		wbytes_q <= WBYTES_W'(budget_q))

endmodule

FILE: verif/frgbb_policy_check.sv
`timescale 1ns / 100ps

module frgbb_policy_check import frgbb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	frgbb_item_if                 items,
	frgbb_result_if               results,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    fail_count,
	output int                    pending
);

	localparam int          REPORT_MAX = 50;
	localparam logic [63:0] BYTES_CAP  = 64'hFF_FFFF_FFFF;

	typedef struct packed {
		logic    accept;
		reason_t reason;
	} verdict_t;

	logic [TS_W-1:0]     due_ms;
	logic [TS_W-1:0]     win_start;
	logic [WBYTES_W-1:0] win_bytes;
	int unsigned         gap_ms;
	longint unsigned     budget;
	verdict_t            verdict_q[$];

	// Advance the gate or the byte window by one beat and give its verdict.
	function automatic verdict_t police_beat(input logic cmd, input logic [TS_W-1:0] fts,
			input logic [PTS_W-1:0] pts, input logic [TS_W-1:0] ing,
			input logic [BYTES_W-1:0] nbytes, input logic key);
		logic [63:0] t;
		logic [63:0] win_clock;
		logic [63:0] nd;
		logic [63:0] sum;
		verdict_t    v;
		t = (fts != '0) ? 64'(fts) : 64'(pts) / 64'd1000;
		v.accept = 1'b1;
		v.reason = RSN_OK;
		if (cmd == CMD_FRAME) begin
			if (t != 0) begin
				if (due_ms == '0)
					due_ms = t[TS_W-1:0];
				if (t < 64'(due_ms)) begin
					v.accept = 1'b0;
					v.reason = RSN_EARLY;
				end else begin
					nd = 64'(due_ms) + 64'(gap_ms);
					if (t > nd + 64'(3 * gap_ms))
						nd = t + 64'(gap_ms);
					due_ms = nd[TS_W-1:0];
				end
			end
		end else begin
			win_clock = (t != 0) ? t : 64'(ing);
			if (win_start == '0 || win_clock == 0 ||
					win_clock >= 64'(win_start) + 64'(WINDOW_MS)) begin
				if (win_clock != 0)
					win_start = win_clock[TS_W-1:0];
				win_bytes = '0;
			end
			sum = 64'(win_bytes) + 64'(nbytes);
			if (sum > budget) begin
				if (!key) begin
					v.accept = 1'b0;
					v.reason = RSN_OVER;
				end else begin
					v.reason = RSN_KEY_OVER;
				end
			end
			if (v.accept)
				win_bytes = (sum > BYTES_CAP) ? BYTES_CAP[WBYTES_W-1:0] : sum[WBYTES_W-1:0];
		end
		return v;
	endfunction

	task automatic note_mismatch(input string field, input logic [1:0] want,
			input logic [1:0] got);
		$error("%s: expected %0d, got %0d", field, want, got);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		int unsigned     fps_v;
		longint unsigned kbps_v;
		verdict_t        want;
		if (!arst_n) begin
			due_ms     = '0;
			win_start  = '0;
			win_bytes  = '0;
			gap_ms     = 1000 / FPS_RST;
			budget     = 64'(KBPS_RST) * BYTES_PER_KBIT;
			verdict_q.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_TARGET_FPS: begin
						fps_v = cfg_wdata[FPS_W-1:0];
						if (fps_v == 0)
							fps_v = 1;
						gap_ms = 1000 / fps_v;
						if (gap_ms == 0)
							gap_ms = 1;
					end
					REG_TARGET_KBPS: begin
						kbps_v = cfg_wdata[KBPS_W-1:0];
						if (kbps_v < KBPS_MIN)
							kbps_v = KBPS_MIN;
						budget = kbps_v * BYTES_PER_KBIT;
					end
					default: ;
				endcase
			end
			// Retire the result first: it always belongs to an older beat.
			if (results.valid && results.ready) begin
				if (verdict_q.size() == 0) begin
					if (fail_count < REPORT_MAX)
						$error("result beat with nothing expected: accept %0d, reason %0d",
							results.accept, results.reason);
					fail_count++;
				end else begin
					want = verdict_q.pop_front();
					if (results.accept !== want.accept)
						note_mismatch("accept", 2'(want.accept), 2'(results.accept));
					if (results.reason !== want.reason)
						note_mismatch("reason", want.reason, results.reason);
				end
			end
			if (items.valid && items.ready)
				verdict_q.push_back(police_beat(items.command, items.frame_ts_ms, items.pts_us,
					items.ingest_ts_ms, items.packet_bytes, items.is_keyframe));
			pending = verdict_q.size();
		end
	end

endmodule

FILE: verif/frame_rate_gate_byte_budget_tb.sv
`timescale 1ns / 100ps

module frame_rate_gate_byte_budget_tb;
	import frgbb_pkg::*;

	// Length of the long result hold-off, in receiver cycles
	localparam int HOLD_CYCLES = 400;
	// Cycles without any beat before the run is declared hung
	localparam int QUIET_LIMIT = 5000;
	localparam int PHASE_BEATS = 100;
	// Max-size keyframes in one window, enough to pile far past any budget
	localparam int SAT_BEATS   = 20;
	localparam logic [TS_W-1:0] TS_MAX = '1;
	localparam logic [63:0]     MASK44 = 64'hFFF_FFFF_FFFF;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic               command;
		logic [TS_W-1:0]    frame_ts;
		logic [PTS_W-1:0]   pts;
		logic [TS_W-1:0]    ingest;
		logic [BYTES_W-1:0] nbytes;
		logic               key;
	} beat_fields_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    fail_count;
	int                    pending;

	idle_mode_t      idle_mode;
	bit              hold_results;
	// Running clocks that keep the random frames and packets well-formed
	longint unsigned frame_clock;
	longint unsigned pkt_clock;
	int unsigned     cur_iv;
	int unsigned     cur_budget;

	frgbb_item_if   item_ch();
	frgbb_result_if result_ch();

	frame_rate_gate_byte_budget uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (item_ch),
		.results   (result_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	frgbb_policy_check policy_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (item_ch),
		.results    (result_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Frame arrival; the packet-only fields get random filler.
	function automatic beat_fields_t frame_beat(input logic [TS_W-1:0] ts,
			input logic [PTS_W-1:0] pts);
		beat_fields_t b;
		b.command  = CMD_FRAME;
		b.frame_ts = ts;
		b.pts      = pts;
		b.ingest   = TS_W'(rand64());
		b.nbytes   = BYTES_W'($urandom);
		b.key      = 1'($urandom);
		return b;
	endfunction

	function automatic beat_fields_t packet_beat(input logic [TS_W-1:0] ts,
			input logic [PTS_W-1:0] pts, input logic [TS_W-1:0] ing,
			input logic [BYTES_W-1:0] nbytes, input logic key);
		beat_fields_t b;
		b.command  = CMD_PACKET;
		b.frame_ts = ts;
		b.pts      = pts;
		b.ingest   = ing;
		b.nbytes   = nbytes;
		b.key      = key;
		return b;
	endfunction

	function automatic bit sender_idles();
		case (idle_mode)
			IDLE_SEND: return $urandom_range(99) < 86;
			IDLE_BOTH: return $urandom_range(99) < 12;
			default:   return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stalls();
		case (idle_mode)
			IDLE_RECV: return $urandom_range(99) < 86;
			IDLE_BOTH: return $urandom_range(99) < 12;
			default:   return 1'b0;
		endcase
	endfunction

	// Mostly paced frames and packets on a rising clock, the rest noise.
	function automatic beat_fields_t random_beat();
		beat_fields_t    b;
		int unsigned     roll;
		int unsigned     lim;
		longint unsigned t;
		longint unsigned now;
		roll = $urandom_range(99);
		b = frame_beat('0, PTS_W'(rand64()));
		if (roll < 40) begin
			// Advance by up to two intervals, now and then lag far enough to catch up
			if ($urandom_range(9) == 0)
				frame_clock += $urandom_range(12 * cur_iv, 4 * cur_iv);
			else
				frame_clock += $urandom_range(2 * cur_iv);
			if (frame_clock < (64'd1 << 45) && $urandom_range(2) == 0)
				b.pts = PTS_W'(frame_clock * 1000 + $urandom_range(999));
			else
				b.frame_ts = TS_W'(frame_clock);
		end else if (roll < 80) begin
			pkt_clock += $urandom_range(350);
			lim = cur_budget / 3;
			b.command = CMD_PACKET;
			b.key     = ($urandom_range(7) == 0);
			if ($urandom_range(15) == 0 || lim > 24'hFF_FFFF)
				b.nbytes = ($urandom_range(1) == 0) ? '1 : BYTES_W'($urandom);
			else
				b.nbytes = BYTES_W'($urandom_range(lim));
			case ($urandom_range(2))
				0: b.frame_ts = TS_W'(pkt_clock);
				1: begin
					if (pkt_clock < (64'd1 << 45))
						b.pts = PTS_W'(pkt_clock * 1000 + $urandom_range(999));
					else
						b.frame_ts = TS_W'(pkt_clock);
				end
				default: begin
					b.pts    = PTS_W'($urandom_range(999));
					b.ingest = TS_W'(pkt_clock);
				end
			endcase
		end else begin
			b.command = 1'($urandom);
			b.nbytes  = BYTES_W'($urandom);
			b.key     = 1'($urandom);
			// Keep noise clocks well below the top of the 48-bit range so the
			// window start never parks where no later clock can move it.
			if ($urandom_range(3) == 0)
				b.frame_ts = '0;
			else
				b.frame_ts = TS_W'(rand64() & MASK44);
			if ($urandom_range(3) == 0)
				b.pts = '0;
			if (b.command == CMD_FRAME)
				b.ingest = TS_W'(rand64());
			else if ($urandom_range(3) == 0)
				b.ingest = '0;
			else
				b.ingest = TS_W'(rand64() & MASK44);
			// Follow the block: a noise clock ahead of ours becomes the new base
			t = (b.frame_ts != '0) ? 64'(b.frame_ts) : 64'(b.pts) / 1000;
			now = (t != 0) ? t : 64'(b.ingest);
			if (b.command == CMD_FRAME && t > frame_clock)
				frame_clock = t;
			if (b.command == CMD_PACKET && now > pkt_clock)
				pkt_clock = now;
		end
		return b;
	endfunction

	// Offer one beat, idling first as the phase asks; return at the falling
	// edge after it was taken, with valid still high.
	task automatic offer(input beat_fields_t b);
		while (sender_idles()) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.command      <= b.command;
		item_ch.frame_ts_ms  <= b.frame_ts;
		item_ch.pts_us       <= b.pts;
		item_ch.ingest_ts_ms <= b.ingest;
		item_ch.packet_bytes <= b.nbytes;
		item_ch.is_keyframe  <= b.key;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drop valid and hold until every expected result has come back.
	task automatic drain();
		item_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// Write both registers on back-to-back cycles; call only while drained.
	task automatic configure(input logic [CFG_DATA_W-1:0] fps_v,
			input logic [CFG_DATA_W-1:0] kbps_v);
		int unsigned f;
		int unsigned k;
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_TARGET_FPS;
		cfg_wdata <= fps_v;
		@(negedge clk);
		cfg_index <= REG_TARGET_KBPS;
		cfg_wdata <= kbps_v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		// Rough pacing figures for shaping the random stimulus
		f = fps_v[FPS_W-1:0];
		if (f == 0)
			f = 1;
		cur_iv = (1000 / f == 0) ? 1 : 1000 / f;
		k = kbps_v;
		if (k < 100)
			k = 100;
		cur_budget = k * 125;
	endtask

	// Receiver: stall per phase, plus one long hold-off counted here.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_results) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_results = 1'b0;
			end
			result_ch.ready <= !receiver_stalls();
		end
	end

	// Watchdog: end the run if no beat moves on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("frame_rate_gate_byte_budget_tb NOT OK");
		$finish;
	end

	initial begin
		logic [CFG_DATA_W-1:0] fps_v;
		logic [CFG_DATA_W-1:0] kbps_v;
		arst_n               = 1'b0;
		cfg_wr_en            = 1'b0;
		cfg_index            = REG_TARGET_FPS;
		cfg_wdata            = '0;
		item_ch.valid        = 1'b0;
		item_ch.command      = CMD_FRAME;
		item_ch.frame_ts_ms  = '0;
		item_ch.pts_us       = '0;
		item_ch.ingest_ts_ms = '0;
		item_ch.packet_bytes = '0;
		item_ch.is_keyframe  = 1'b0;
		hold_results         = 1'b0;
		idle_mode            = IDLE_NONE;
		cur_iv               = 33;
		cur_budget           = 500000;
		frame_clock          = 0;
		pkt_clock            = 0;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Frame gate under the reset rate (33 ms interval)
		offer(frame_beat('0, '0));                       // no time at all: pass
		offer(frame_beat('0, 56'd999));                  // pts below 1 ms: still no time
		offer(frame_beat(48'd1000, PTS_W'(rand64())));   // gate starts here
		offer(frame_beat(48'd1010, PTS_W'(rand64())));   // before due
		offer(frame_beat(48'd1033, PTS_W'(rand64())));   // exactly on due
		offer(frame_beat(48'd5000, PTS_W'(rand64())));   // lags, catch up
		offer(frame_beat('0, 56'd5_033_000));            // time from pts
		offer(frame_beat('0, '1));                       // largest pts
		offer(frame_beat(TS_MAX, '0));                   // due wraps past the top
		offer(frame_beat(48'd10, '0));                   // before the wrapped due
		offer(frame_beat(TS_MAX - 48'd32, '0));          // due wraps to zero
		offer(frame_beat(48'd7, '0));                    // gate restarts

		// Byte window under the reset budget (500000 bytes)
		offer(packet_beat('0, '0, '0, 24'd100, 1'b0));            // no clock
		offer(packet_beat('0, 56'd999, 48'd2000, '0, 1'b0));      // ingest opens window
		offer(packet_beat('0, '0, 48'd2100, 24'd400000, 1'b0));
		offer(packet_beat(48'd2200, '0, '0, 24'd200000, 1'b0));   // over budget
		offer(packet_beat('0, 56'd2_300_000, '0, '1, 1'b1));      // keyframe over budget
		offer(packet_beat(48'd2999, '0, '0, 24'd1, 1'b0));        // last ms of window
		offer(packet_beat(48'd3000, '0, '0, 24'd1, 1'b0));        // window restarts
		offer(packet_beat(48'd3500, '0, '0, 24'd499999, 1'b0));   // lands on the budget
		offer(packet_beat(48'd3600, '0, '0, 24'd1, 1'b0));        // one byte over
		offer(packet_beat('0, '0, '0, 24'd1, 1'b0));              // no clock clears count

		// Pile keyframes far past the budget, then check an empty packet is dropped
		repeat (SAT_BEATS)
			offer(packet_beat(48'd10_000_000, PTS_W'(rand64()), TS_W'(rand64()), '1, 1'b1));
		offer(packet_beat(48'd10_000_500, '0, '0, '0, 1'b0));

		frame_clock = 100;
		pkt_clock   = 20_000_000;

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					fps_v  = 20'd1;
					kbps_v = 20'd100;
				end
				1: begin
					fps_v  = 20'd1000;
					kbps_v = 20'd1000000;
				end
				2: begin
					fps_v  = '0;
					kbps_v = '0;
				end
				3: begin
					fps_v  = '1;
					kbps_v = '1;
				end
				4: begin
					fps_v  = CFG_DATA_W'($urandom);
					kbps_v = CFG_DATA_W'($urandom_range(1048575, 100));
				end
				default: begin
					fps_v  = CFG_DATA_W'($urandom_range(31, 2));
					kbps_v = CFG_DATA_W'($urandom_range(5000, 100));
				end
			endcase
			drain();
			configure(fps_v, kbps_v);
			idle_mode = idle_mode_t'(phase % 4);
			// First phase: back the block up against a stalled receiver
			if (phase == 0)
				hold_results = 1'b1;
			repeat (PHASE_BEATS)
				offer(random_beat());
		end

		drain();
		repeat (10) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("frame_rate_gate_byte_budget_tb OK");
		else
			$display("frame_rate_gate_byte_budget_tb NOT OK");
		$finish;
	end

endmodule

FILE: frame_rate_gate_byte_budget.f
+incdir+hdl
hdl/frgbb_pkg.sv
hdl/frgbb_if.sv
hdl/frgbb_time_pipe.sv
hdl/frame_rate_gate_byte_budget.sv
verif/frgbb_policy_check.sv
verif/frame_rate_gate_byte_budget_tb.sv
